// ===== rtl/selected_row_gram_matrix_assert.svh =====
// Assertion macros for the selected-row Gram matrix block.
`ifndef SELECTED_ROW_GRAM_MATRIX_ASSERT_SVH
`define SELECTED_ROW_GRAM_MATRIX_ASSERT_SVH

// Same-cycle implication under reset.
`define SRGM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("srgm assertion failed");

// Next-cycle implication under reset.
`define SRGM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("srgm assertion failed");

`endif

// ===== rtl/srgm_pkg.sv =====
// Types, widths and codes shared by the selected-row Gram matrix block.
`timescale 1ns / 1ps
`default_nettype none
package srgm_pkg;
	localparam int ELEM_W = 32;
	localparam int ACC_W  = 64;
	localparam int POS_W  = 3;
	localparam int RANK_W = 4;
	localparam int APB_AW = 3;
	localparam int APB_DW = 32;

	localparam logic CMD_PUSH   = 1'b0;
	localparam logic CMD_FINISH = 1'b1;

	localparam logic REG_RANK_IN_USE = 1'b0;
	localparam logic [RANK_W-1:0] RANK_RESET = 4'd8;

	localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

	typedef struct packed {
		logic                     cmd;
		logic signed [ELEM_W-1:0] element_value;
	} item_t;

	typedef struct packed {
		logic signed [ACC_W-1:0] gram_value;
		logic [POS_W-1:0]        result_row;
		logic [POS_W-1:0]        result_col;
		logic                    last_entry;
	} result_t;

	typedef struct packed {
		logic rd_en;
		logic wr_en;
		logic clr_all;
	} gram_ctl_t;

	function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] a,
			input logic [ACC_W-1:0] b);
		logic [ACC_W-1:0] s;
		s = a + b;
		if (a[ACC_W-1] == b[ACC_W-1] && s[ACC_W-1] != a[ACC_W-1]) begin
			s = a[ACC_W-1] ? ACC_MIN : ACC_MAX;
		end
		return s;
	endfunction
endpackage
`default_nettype wire

// ===== rtl/srgm_row_buf.sv =====
// Row element buffer: one write port, two registered read ports.
`timescale 1ns / 1ps
`default_nettype none
module srgm_row_buf #(
	parameter int AW = 3
) (
	input  wire logic                             clk,
	input  wire logic                             wr_en,
	input  wire logic [AW-1:0]                    wr_addr,
	input  wire logic signed [srgm_pkg::ELEM_W-1:0] wr_data,
	input  wire logic [AW-1:0]                    rd_addr_a,
	input  wire logic [AW-1:0]                    rd_addr_b,
	output logic signed [srgm_pkg::ELEM_W-1:0]    rd_data_a,
	output logic signed [srgm_pkg::ELEM_W-1:0]    rd_data_b
);
	import srgm_pkg::*;

	localparam int DEPTH = 1 << AW;

	logic signed [ELEM_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_a <= mem_q[rd_addr_a];
		rd_data_b <= mem_q[rd_addr_b];
	end
endmodule
`default_nettype wire

// ===== rtl/srgm_mac_unit.sv =====
// Shared multiply-accumulate unit: registered 32x32 product, saturating add.
`timescale 1ns / 1ps
`default_nettype none
module srgm_mac_unit (
	input  wire logic                               clk,
	input  wire logic                               en,
	input  wire logic signed [srgm_pkg::ELEM_W-1:0] a,
	input  wire logic signed [srgm_pkg::ELEM_W-1:0] b,
	input  wire logic [srgm_pkg::ACC_W-1:0]         acc,
	output logic [srgm_pkg::ACC_W-1:0]              sum
);
	import srgm_pkg::*;

	logic signed [ACC_W-1:0] prod_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s2 <= ACC_W'(a) * ACC_W'(b);
		end
	end

	assign sum = sat_add(acc, prod_s2);
endmodule
`default_nettype wire

// ===== rtl/srgm_gram_store.sv =====
// Gram accumulator store with per-entry valid bits; invalid entries read as zero.
`timescale 1ns / 1ps
`default_nettype none
module srgm_gram_store #(
	parameter int AW = 6
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire srgm_pkg::gram_ctl_t        ctl,
	input  wire logic [AW-1:0]              rd_addr,
	input  wire logic [AW-1:0]              wr_addr,
	input  wire logic [srgm_pkg::ACC_W-1:0] wr_data,
	output logic [srgm_pkg::ACC_W-1:0]      rd_data
);
	import srgm_pkg::*;

	localparam int DEPTH = 1 << AW;

	logic [ACC_W-1:0] mem_q [DEPTH];
	logic [DEPTH-1:0] vld_q;
	logic [ACC_W-1:0] rd_data_q;
	logic             rd_vld_q;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (ctl.rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (ctl.clr_all) begin
				vld_q <= '0;
			end else if (ctl.wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (ctl.rd_en) begin
				rd_vld_q <= vld_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_vld_q ? rd_data_q : '0;
endmodule
`default_nettype wire

// ===== rtl/selected_row_gram_matrix.sv =====
// Top level of the selected-row Gram matrix accumulator.
// Rows stream in one element per beat (cmd push); the push that completes a row of
// r = rank_in_use elements (0 reads as 1, above RANK as RANK) then holds item_stall
// high while one shared 32x32 multiplier and 64-bit saturating adder walk every
// (i, j) pair of the row into the accumulator store. A finish beat emits the r*r
// entries in row-major order, each as a store read and then a load of the result
// register, which waits while the result side stalls; it marks the last one and
// clears the store.
`timescale 1ns / 1ps
`default_nettype none
`include "selected_row_gram_matrix_assert.svh"
module selected_row_gram_matrix #(
	parameter int RANK = 8
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        item_valid,
	output logic                             item_stall,
	input  wire srgm_pkg::item_t             item,
	output logic                             result_valid,
	input  wire logic                        result_stall,
	output srgm_pkg::result_t                result,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [srgm_pkg::APB_AW-1:0] paddr,
	input  wire logic [srgm_pkg::APB_DW-1:0] pwdata,
	output logic [srgm_pkg::APB_DW-1:0]      prdata,
	output logic                             pready
);
	import srgm_pkg::*;

	localparam int IDX_W = (RANK > 1) ? $clog2(RANK) : 1;
	localparam int CNT_W = $clog2(RANK + 1);
	localparam int GA_W  = 2 * IDX_W;

	localparam logic [2:0] ST_IDLE     = 3'd0;
	localparam logic [2:0] ST_MAC      = 3'd1;
	localparam logic [2:0] ST_DRAIN    = 3'd2;
	localparam logic [2:0] ST_EMIT_RD  = 3'd3;
	localparam logic [2:0] ST_EMIT_PUT = 3'd4;

	logic [2:0]        state_q;
	logic [RANK_W-1:0] rank_q;
	logic [IDX_W-1:0]  cnt_q;
	logic [IDX_W-1:0]  ri_q;
	logic [IDX_W-1:0]  cj_q;
	logic              issue_s1;
	logic              issue_s2;
	logic [GA_W-1:0]   addr_s1;
	logic [GA_W-1:0]   addr_s2;
	result_t           result_q;
	logic              result_valid_q;

	logic [CNT_W-1:0]  eff_r;
	logic [IDX_W-1:0]  last_idx;
	logic              item_fire;
	logic              cfg_wr;
	logic              out_free;
	logic              row_done;
	logic              pair_last;

	logic signed [ELEM_W-1:0] a_s1;
	logic signed [ELEM_W-1:0] b_s1;
	logic [ACC_W-1:0]         acc_rd;
	logic [ACC_W-1:0]         acc_sum;
	gram_ctl_t                gram_ctl;
	logic [GA_W-1:0]          gram_rd_addr;

	always_comb begin
		if (rank_q == '0) begin
			eff_r = CNT_W'(1);
		end else if (rank_q > RANK_W'(RANK)) begin
			eff_r = CNT_W'(RANK);
		end else begin
			eff_r = rank_q[CNT_W-1:0];
		end
	end

	assign last_idx  = IDX_W'(eff_r - CNT_W'(1));
	assign item_stall = (state_q != ST_IDLE);
	assign item_fire = item_valid && !item_stall;
	assign cfg_wr    = psel && penable && pwrite && pready &&
		(paddr[2] == REG_RANK_IN_USE);
	assign out_free  = !result_valid_q || !result_stall;
	assign row_done  = (cnt_q == last_idx);
	assign pair_last = (ri_q == last_idx) && (cj_q == last_idx);

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_RANK_IN_USE) ? APB_DW'(rank_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			rank_q         <= RANK_RESET;
			cnt_q          <= '0;
			ri_q           <= '0;
			cj_q           <= '0;
			issue_s1       <= 1'b0;
			issue_s2       <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			issue_s1 <= (state_q == ST_MAC);
			issue_s2 <= issue_s1;
			if (state_q == ST_EMIT_PUT && out_free) begin
				result_valid_q <= 1'b1;
			end else if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end
			if (cfg_wr) begin
				rank_q <= pwdata[RANK_W-1:0];
			end
			if (cfg_wr || (item_fire && (item.cmd == CMD_FINISH || row_done))) begin
				cnt_q <= '0;
			end else if (item_fire) begin
				cnt_q <= cnt_q + IDX_W'(1);
			end
			case (state_q)
				ST_IDLE: begin
					if (item_fire) begin
						ri_q <= '0;
						cj_q <= '0;
						if (item.cmd == CMD_FINISH) begin
							state_q <= ST_EMIT_RD;
						end else if (row_done) begin
							state_q <= ST_MAC;
						end
					end
				end
				ST_MAC: begin
					if (cj_q == last_idx) begin
						cj_q <= '0;
						if (ri_q == last_idx) begin
							state_q <= ST_DRAIN;
						end else begin
							ri_q <= ri_q + IDX_W'(1);
						end
					end else begin
						cj_q <= cj_q + IDX_W'(1);
					end
				end
				ST_DRAIN: begin
					if (!issue_s1 && !issue_s2) begin
						state_q <= ST_IDLE;
					end
				end
				ST_EMIT_RD: begin
					state_q <= ST_EMIT_PUT;
				end
				ST_EMIT_PUT: begin
					if (out_free) begin
						if (pair_last) begin
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_EMIT_RD;
							if (cj_q == last_idx) begin
								cj_q <= '0;
								ri_q <= ri_q + IDX_W'(1);
							end else begin
								cj_q <= cj_q + IDX_W'(1);
							end
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= {ri_q, cj_q};
		addr_s2 <= addr_s1;
		if (state_q == ST_EMIT_PUT && out_free) begin
			result_q.gram_value <= acc_rd;
			result_q.result_row <= POS_W'(ri_q);
			result_q.result_col <= POS_W'(cj_q);
			result_q.last_entry <= pair_last;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	srgm_row_buf #(
		.AW(IDX_W)
	) u_row_buf (
		.clk      (clk),
		.wr_en    (item_fire && item.cmd == CMD_PUSH),
		.wr_addr  (cnt_q),
		.wr_data  (item.element_value),
		.rd_addr_a(ri_q),
		.rd_addr_b(cj_q),
		.rd_data_a(a_s1),
		.rd_data_b(b_s1)
	);

	srgm_mac_unit u_mac (
		.clk(clk),
		.en (issue_s1),
		.a  (a_s1),
		.b  (b_s1),
		.acc(acc_rd),
		.sum(acc_sum)
	);

	always_comb begin
		gram_ctl.rd_en   = issue_s1 || (state_q == ST_EMIT_RD);
		gram_ctl.wr_en   = issue_s2;
		gram_ctl.clr_all = (state_q == ST_EMIT_PUT) && out_free && pair_last;
		gram_rd_addr     = (state_q == ST_EMIT_RD) ? {ri_q, cj_q} : addr_s1;
	end

	srgm_gram_store #(
		.AW(GA_W)
	) u_gram (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (gram_ctl),
		.rd_addr(gram_rd_addr),
		.wr_addr(addr_s2),
		.wr_data(acc_sum),
		.rd_data(acc_rd)
	);

	`SRGM_ASSERT_NEXT(a_row_starts_mac, clk, arst_n, item_fire && item.cmd == CMD_PUSH && row_done && !cfg_wr, state_q == ST_MAC)
	`SRGM_ASSERT_IMPL(a_acc_write_in_mac, clk, arst_n, issue_s2, state_q == ST_MAC || state_q == ST_DRAIN)
	`SRGM_ASSERT_IMPL(a_count_in_row, clk, arst_n, 1'b1, cnt_q <= last_idx)
endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for the selected-row Gram matrix accumulator.
`timescale 1ns / 1ps
module tb_top;
	import srgm_pkg::*;

	localparam int GRAM_RANK = 8;
	localparam int SETTLE_CYCLES = 80;
	localparam logic [APB_AW-1:0] RANK_ADDR = APB_AW'(4 * REG_RANK_IN_USE);

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              item_valid = 1'b0;
	logic              item_stall;
	item_t             item = '0;
	logic              result_valid;
	logic              result_stall = 1'b0;
	result_t           result;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [APB_AW-1:0] paddr = '0;
	logic [APB_DW-1:0] pwdata = '0;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned errors = 0;
	int unsigned items_sent = 0;
	int unsigned entries_checked = 0;
	int unsigned sets_finished = 0;
	int unsigned saturated_seen = 0;

	logic [RANK_W-1:0]        rank_reg;
	logic signed [ELEM_W-1:0] row_elems [GRAM_RANK];
	int unsigned              elems_held;
	logic signed [ACC_W-1:0]  gram_acc [64];
	result_t                  gram_entries_due [$];

	selected_row_gram_matrix #(
		.RANK(GRAM_RANK)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #2 clk = ~clk;

	function automatic int unsigned active_rank();
		if (rank_reg == 0) begin
			return 1;
		end
		if (rank_reg > GRAM_RANK) begin
			return GRAM_RANK;
		end
		return rank_reg;
	endfunction

	function automatic logic signed [ACC_W-1:0] clamp_sum(input logic signed [ACC_W-1:0] a,
			input logic signed [ACC_W-1:0] b);
		logic [ACC_W:0] s;
		s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
		if (s[ACC_W] != s[ACC_W-1]) begin
			return s[ACC_W] ? ACC_MIN : ACC_MAX;
		end
		return s[ACC_W-1:0];
	endfunction

	task automatic clear_gram();
		foreach (gram_acc[k]) begin
			gram_acc[k] = '0;
		end
		elems_held = 0;
	endtask

	task automatic predict_gram(input item_t it);
		int unsigned r;
		logic signed [ACC_W-1:0] wa;
		logic signed [ACC_W-1:0] wb;
		result_t e;
		r = active_rank();
		if (it.cmd == CMD_PUSH) begin
			row_elems[elems_held] = it.element_value;
			if (elems_held + 1 >= r) begin
				for (int i = 0; i < r; i++) begin
					for (int j = 0; j < r; j++) begin
						wa = row_elems[i];
						wb = row_elems[j];
						gram_acc[i * 8 + j] = clamp_sum(gram_acc[i * 8 + j], wa * wb);
					end
				end
				elems_held = 0;
			end else begin
				elems_held++;
			end
		end else begin
			for (int i = 0; i < r; i++) begin
				for (int j = 0; j < r; j++) begin
					e.gram_value = gram_acc[i * 8 + j];
					e.result_row = POS_W'(i);
					e.result_col = POS_W'(j);
					e.last_entry = (i == r - 1) && (j == r - 1);
					gram_entries_due.push_back(e);
				end
			end
			clear_gram();
			sets_finished++;
		end
	endtask

	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && result_valid && !result_stall) begin
			entries_checked++;
			if (result.gram_value == ACC_MAX || result.gram_value == ACC_MIN) begin
				saturated_seen++;
			end
			if (gram_entries_due.size() == 0) begin
				errors++;
				if (errors <= 20) begin
					$display("%0t: unexpected entry value %h row %0d col %0d last %0b", $time,
						result.gram_value, result.result_row, result.result_col,
						result.last_entry);
				end
			end else begin
				want = gram_entries_due.pop_front();
				if (result.gram_value !== want.gram_value || result.result_row !== want.result_row
						|| result.result_col !== want.result_col
						|| result.last_entry !== want.last_entry) begin
					errors++;
					if (errors <= 20) begin
						$display("%0t: expected value %h row %0d col %0d last %0b", $time,
							want.gram_value, want.result_row, want.result_col, want.last_entry);
						$display("%0t: actual   value %h row %0d col %0d last %0b", $time,
							result.gram_value, result.result_row, result.result_col,
							result.last_entry);
					end
				end
			end
		end
		result_stall <= ($urandom_range(0, 99) < recv_stall_pct);
	end

	task automatic send_item(input item_t it);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		@(posedge clk);
		while (item_stall) begin
			@(posedge clk);
		end
		predict_gram(it);
		items_sent++;
	endtask

	task automatic push_element(input logic signed [ELEM_W-1:0] value);
		item_t it;
		it.cmd = CMD_PUSH;
		it.element_value = value;
		send_item(it);
	endtask

	task automatic finish_set();
		item_t it;
		it.cmd = CMD_FINISH;
		it.element_value = $urandom;
		send_item(it);
	endtask

	task automatic stop_items();
		item_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_drained();
		while (gram_entries_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_rank(input logic [RANK_W-1:0] value);
		logic [APB_DW-1:0] word;
		stop_items();
		wait_drained();
		word = $urandom;
		word[RANK_W-1:0] = value;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= RANK_ADDR;
		pwdata <= word;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) begin
			@(posedge clk);
		end
		rank_reg = value;
		elems_held = 0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) begin
			@(posedge clk);
		end
		if (prdata !== APB_DW'(value)) begin
			errors++;
			$display("%0t: rank readback expected %h, actual %h", $time, APB_DW'(value), prdata);
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	function automatic logic signed [ELEM_W-1:0] pick_element();
		int near_zero;
		near_zero = int'($urandom_range(0, 262143)) - 131072;
		case ($urandom_range(0, 9))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'h0000_0000;
			3, 4: return near_zero;
			default: return $urandom;
		endcase
	endfunction

	task automatic test_empty_finish();
		finish_set();
	endtask

	task automatic test_rank_limits();
		write_rank(4'd0);
		push_element(32'h8000_0000);
		finish_set();
		write_rank(4'd15);
		push_element(32'h8000_0000);
		push_element(32'h7FFF_FFFF);
		push_element(32'h0000_0000);
		push_element(32'h0000_0001);
		push_element(32'hFFFF_FFFF);
		push_element(32'h0001_0000);
		push_element(32'hAAAA_AAAA);
		push_element(32'h5555_5555);
		finish_set();
	endtask

	task automatic test_saturation();
		write_rank(4'd2);
		repeat (3) begin
			push_element(32'h8000_0000);
			push_element(32'h7FFF_FFFF);
		end
		finish_set();
	endtask

	task automatic test_dropped_rows();
		write_rank(4'd3);
		push_element(32'h1234_5678);
		push_element(32'h8765_4321);
		write_rank(4'd3);
		push_element(32'h0002_0000);
		push_element(32'hFFFE_0000);
		push_element(32'h7FFF_FFFF);
		push_element(32'h0F0F_0F0F);
		finish_set();
	endtask

	task automatic test_random(input int unsigned idle_pct, input int unsigned stall_pct,
			input int unsigned item_budget);
		int unsigned start_items;
		int unsigned rows;
		int unsigned r;
		logic [RANK_W-1:0] rank_pick;
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		start_items = items_sent;
		while (items_sent - start_items < item_budget) begin
			case ($urandom_range(0, 7))
				0: rank_pick = 4'd1;
				1: rank_pick = 4'd8;
				2: rank_pick = 4'd0;
				3: rank_pick = RANK_W'($urandom_range(9, 15));
				default: rank_pick = RANK_W'($urandom_range(2, 7));
			endcase
			write_rank(rank_pick);
			r = active_rank();
			rows = $urandom_range(0, 4);
			repeat (rows) begin
				repeat (r) push_element(pick_element());
			end
			if (r > 1 && $urandom_range(0, 4) == 0) begin
				repeat ($urandom_range(1, r - 1)) push_element(pick_element());
			end
			finish_set();
			if (r > 1 && $urandom_range(0, 5) == 0) begin
				repeat ($urandom_range(1, r - 1)) push_element(pick_element());
			end
		end
	endtask

	initial begin
		rank_reg = RANK_RESET;
		clear_gram();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_finish();
		test_rank_limits();
		test_saturation();
		test_dropped_rows();
		test_random(0, 0, 88);
		test_random(58, 0, 88);
		test_random(0, 58, 88);
		test_random(31, 31, 88);
		stop_items();
		wait_drained();
		$display("covered %0d items and %0d Gram entries over %0d finished sets,",
			items_sent, entries_checked, sets_finished);
		$display("ranks 0 to 15, mid-row rank writes, dropped rows, %0d saturated entries",
			saturated_seen);
		if (errors == 0 && gram_entries_due.size() == 0) begin
			$display("selected_row_gram_matrix: match");
		end else begin
			$display("selected_row_gram_matrix: mismatch");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("selected_row_gram_matrix: mismatch");
		$finish;
	end
endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/srgm_pkg.sv
rtl/srgm_row_buf.sv
rtl/srgm_mac_unit.sv
rtl/srgm_gram_store.sv
rtl/selected_row_gram_matrix.sv
tb/tb_top.sv
